### src/asrp_pkg.sv
package asrp_pkg;

   localparam int DATA_BITS = 8;
   localparam int BYTE_BITS = 8;
   localparam int PERIOD_BITS = 16;
   localparam int COUNT_BITS = 17;
   localparam int INDEX_BITS = 4;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [PERIOD_BITS-1:0] BIT_PERIOD_RESET = 16'd200;
   localparam logic PARITY_ODD_RESET = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_BIT_PERIOD = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PARITY_ODD = 2'd1;

   typedef enum logic [2:0] {
      PHASE_HUNT    = 3'b001,
      PHASE_SAMPLE  = 3'b010,
      PHASE_DELIVER = 3'b100
   } phase_type;

   typedef struct packed {
      logic                 fire;
      logic [BYTE_BITS-1:0] data_byte;
      logic                 parity_ok;
   } result_type;

endpackage

### src/asrp_req_if.sv
interface asrp_req_if;
   logic valid;
   logic ready;
   logic line_level;

   modport source (output valid, output line_level, input ready);
   modport sink (input valid, input line_level, output ready);
endinterface

### src/asrp_rsp_if.sv
interface asrp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [asrp_pkg::BYTE_BITS-1:0] data_byte;
   logic                           parity_ok;

   modport source (output valid, output data_byte, output parity_ok, input ready);
   modport sink (input valid, input data_byte, input parity_ok, output ready);
endinterface

### src/asrp_core.sv
module asrp_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic                                line_level,
   input  logic                                csr_write_enable,
   input  logic [asrp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [asrp_pkg::PERIOD_BITS-1:0]    csr_write_data,
   output logic                                deliver_due,
   output asrp_pkg::result_type                result
);

   asrp_pkg::phase_type                phase_ff, phase_in;
   logic [asrp_pkg::COUNT_BITS-1:0]    tick_count_ff, tick_count_in;
   logic [asrp_pkg::INDEX_BITS-1:0]    bit_index_ff, bit_index_in;
   logic [asrp_pkg::BYTE_BITS-1:0]     shift_data_ff, shift_data_in;
   logic                               ones_parity_ff, ones_parity_in;
   logic                               parity_sample_ff, parity_sample_in;
   logic [asrp_pkg::PERIOD_BITS-1:0]   bit_period_ff, bit_period_in;
   logic                               parity_odd_ff, parity_odd_in;

   logic                               expired;
   logic [asrp_pkg::COUNT_BITS-1:0]    period_ext;
   logic [asrp_pkg::COUNT_BITS-1:0]    start_wait;

   assign expired = (tick_count_ff <= asrp_pkg::COUNT_BITS'(1));
   assign period_ext = asrp_pkg::COUNT_BITS'(bit_period_ff);
   assign start_wait = period_ext + (period_ext >> 1);
   assign deliver_due = (phase_ff == asrp_pkg::PHASE_DELIVER) && expired;

   always_comb begin
      bit_period_in = bit_period_ff;
      parity_odd_in = parity_odd_ff;
      if (csr_write_enable) begin
         case (csr_index)
            asrp_pkg::CSR_BIT_PERIOD: bit_period_in = csr_write_data;
            asrp_pkg::CSR_PARITY_ODD: parity_odd_in = csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in = phase_ff;
      tick_count_in = tick_count_ff;
      bit_index_in = bit_index_ff;
      shift_data_in = shift_data_ff;
      ones_parity_in = ones_parity_ff;
      parity_sample_in = parity_sample_ff;
      result.fire = 1'b0;
      result.data_byte = shift_data_ff;
      result.parity_ok = ((ones_parity_ff ^ parity_sample_ff) == parity_odd_ff);
      if (accept) begin
         case (phase_ff)
            asrp_pkg::PHASE_SAMPLE: begin
               if (expired) begin
                  if (bit_index_ff < asrp_pkg::INDEX_BITS'(asrp_pkg::DATA_BITS)) begin
                     if (line_level
                         && bit_index_ff < asrp_pkg::INDEX_BITS'(asrp_pkg::BYTE_BITS)) begin
                        shift_data_in[bit_index_ff[2:0]] = 1'b1;
                        ones_parity_in = ~ones_parity_ff;
                     end
                     bit_index_in = bit_index_ff + asrp_pkg::INDEX_BITS'(1);
                  end else begin
                     parity_sample_in = line_level;
                     phase_in = asrp_pkg::PHASE_DELIVER;
                  end
                  tick_count_in = period_ext;
               end else begin
                  tick_count_in = tick_count_ff - asrp_pkg::COUNT_BITS'(1);
               end
            end
            asrp_pkg::PHASE_DELIVER: begin
               if (expired) begin
                  tick_count_in = '0;
                  result.fire = 1'b1;
                  phase_in = asrp_pkg::PHASE_HUNT;
               end else begin
                  tick_count_in = tick_count_ff - asrp_pkg::COUNT_BITS'(1);
               end
            end
            default: begin
               phase_in = asrp_pkg::PHASE_HUNT;
               if (!line_level) begin
                  phase_in = asrp_pkg::PHASE_SAMPLE;
                  tick_count_in = start_wait;
                  bit_index_in = '0;
                  shift_data_in = '0;
                  ones_parity_in = 1'b0;
                  parity_sample_in = 1'b0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= asrp_pkg::PHASE_HUNT;
         tick_count_ff <= '0;
         bit_index_ff <= '0;
         shift_data_ff <= '0;
         ones_parity_ff <= 1'b0;
         parity_sample_ff <= 1'b0;
         bit_period_ff <= asrp_pkg::BIT_PERIOD_RESET;
         parity_odd_ff <= asrp_pkg::PARITY_ODD_RESET;
      end else begin
         phase_ff <= phase_in;
         tick_count_ff <= tick_count_in;
         bit_index_ff <= bit_index_in;
         shift_data_ff <= shift_data_in;
         ones_parity_ff <= ones_parity_in;
         parity_sample_ff <= parity_sample_in;
         bit_period_ff <= bit_period_in;
         parity_odd_ff <= parity_odd_in;
      end
   end

endmodule

### src/asrp_out_reg.sv
module asrp_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  asrp_pkg::result_type result,
   output logic                 full,
   asrp_rsp_if.source           rsp
);

   logic                           valid_ff, valid_in;
   logic [asrp_pkg::BYTE_BITS-1:0] data_byte_ff, data_byte_in;
   logic                           parity_ok_ff, parity_ok_in;

   always_comb begin
      valid_in = valid_ff;
      data_byte_in = data_byte_ff;
      parity_ok_in = parity_ok_ff;
      if (result.fire) begin
         valid_in = 1'b1;
         data_byte_in = result.data_byte;
         parity_ok_in = result.parity_ok;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_byte_ff <= data_byte_in;
      parity_ok_ff <= parity_ok_in;
   end

   assign full = valid_ff && !rsp.ready;
   assign rsp.valid = valid_ff;
   assign rsp.data_byte = data_byte_ff;
   assign rsp.parity_ok = parity_ok_ff;

endmodule

### src/async_serial_receiver_parity_unit.sv
// Output: a byte appears on rsp in the cycle after the delivery sample, which comes
//   after the parity sample of that byte; bit period 0 counts as 1.
// Throughput: one line sample per cycle; req stalls only when a finished
//   byte is due while the previous one still waits in the output register.
// Reset: synchronous, active high; hunts for a start bit, bit period 200, odd parity.
module async_serial_receiver_parity_unit (
   input  logic                                clock,
   input  logic                                reset,
   asrp_req_if.sink                            req_ch,
   asrp_rsp_if.source                          rsp_ch,
   input  logic                                csr_write_enable,
   input  logic [asrp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [asrp_pkg::PERIOD_BITS-1:0]    csr_write_data
);

   logic                 accept;
   logic                 deliver_due;
   logic                 out_full;
   asrp_pkg::result_type result;

   assign req_ch.ready = !(deliver_due && out_full);
   assign accept = req_ch.valid && req_ch.ready;

   asrp_core u_core (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .line_level       (req_ch.line_level),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .deliver_due      (deliver_due),
      .result           (result)
   );

   asrp_out_reg u_out_reg (
      .clock  (clock),
      .reset  (reset),
      .result (result),
      .full   (out_full),
      .rsp    (rsp_ch)
   );

endmodule

### src/asrp_checker.sv
module asrp_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [asrp_pkg::BYTE_BITS-1:0] rsp_data_byte
);

   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_byte);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("rsp transaction dropped");

   property p_reset_clears;
      @(posedge clock) reset |=> !rsp_valid;
   endproperty
   a_reset_clears: assert property (p_reset_clears) else $error("rsp valid after reset");

   property p_stall_cause;
      @(posedge clock) disable iff (reset)
         req_valid && !req_ready |-> rsp_valid && !rsp_ready;
   endproperty
   a_stall_cause: assert property (p_stall_cause)
      else $error("req stalled with output free");

endmodule

bind async_serial_receiver_parity_unit asrp_checker u_asrp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_data_byte (rsp_ch.data_byte)
);

### dv/async_serial_receiver_parity_unit_test.sv
module async_serial_receiver_parity_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES = 40;
   localparam int RANDOM_SETTINGS = 3;
   localparam int FRAMES_PER_SETTING = 3;
   localparam int CSR_SLOTS = 2 ** asrp_pkg::CSR_INDEX_BITS;

   typedef struct packed {
      logic [asrp_pkg::BYTE_BITS-1:0] data_byte;
      logic                           parity_ok;
   } rx_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable;
   logic [asrp_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [asrp_pkg::PERIOD_BITS-1:0] csr_write_data;

   asrp_req_if req_bus ();
   asrp_rsp_if rsp_bus ();

   async_serial_receiver_parity_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_bus),
      .rsp_ch           (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   // receiver shadow state
   asrp_pkg::phase_type              rx_phase = asrp_pkg::PHASE_HUNT;
   logic [asrp_pkg::COUNT_BITS-1:0]  rx_ticks = '0;
   logic [asrp_pkg::INDEX_BITS-1:0]  rx_index = '0;
   logic [asrp_pkg::BYTE_BITS-1:0]   rx_shift = '0;
   logic                             rx_ones = 1'b0;
   logic                             rx_parity_bit = 1'b0;
   logic [asrp_pkg::PERIOD_BITS-1:0] cfg_bit_period = asrp_pkg::BIT_PERIOD_RESET;
   logic                             cfg_parity_odd = asrp_pkg::PARITY_ODD_RESET;

   rx_byte_type pending_bytes[$];

   bit tx_idling = 1'b1;
   bit rx_idling = 1'b1;
   int errors = 0;
   int bytes_checked = 0;
   int samples_sent = 0;
   int frames_sent = 0;
   int settings_used = 1;
   int quiet_cycles = 0;

   task automatic decode_line_sample(input logic level);
      logic due;
      logic [31:0] first_wait;
      rx_byte_type done;
      begin
         due = 1'b0;
         if (rx_phase == asrp_pkg::PHASE_SAMPLE || rx_phase == asrp_pkg::PHASE_DELIVER) begin
            if (rx_ticks <= asrp_pkg::COUNT_BITS'(1)) begin
               rx_ticks = '0;
               due = 1'b1;
            end else begin
               rx_ticks = rx_ticks - asrp_pkg::COUNT_BITS'(1);
            end
         end
         case (rx_phase)
            asrp_pkg::PHASE_SAMPLE: begin
               if (due) begin
                  if (rx_index < asrp_pkg::DATA_BITS) begin
                     if (level && rx_index < asrp_pkg::BYTE_BITS) begin
                        rx_shift[rx_index[2:0]] = 1'b1;
                        rx_ones = ~rx_ones;
                     end
                     rx_index = rx_index + asrp_pkg::INDEX_BITS'(1);
                  end else begin
                     rx_parity_bit = level;
                     rx_phase = asrp_pkg::PHASE_DELIVER;
                  end
                  rx_ticks = {1'b0, cfg_bit_period};
               end
            end
            asrp_pkg::PHASE_DELIVER: begin
               if (due) begin
                  done.data_byte = rx_shift;
                  done.parity_ok = ((rx_ones ^ rx_parity_bit) == cfg_parity_odd);
                  pending_bytes.push_back(done);
                  rx_phase = asrp_pkg::PHASE_HUNT;
               end
            end
            default: begin
               rx_phase = asrp_pkg::PHASE_HUNT;
               if (!level) begin
                  first_wait = (32'(cfg_bit_period) * 3) / 2;
                  rx_phase = asrp_pkg::PHASE_SAMPLE;
                  rx_ticks = first_wait[asrp_pkg::COUNT_BITS-1:0];
                  rx_index = '0;
                  rx_shift = '0;
                  rx_ones = 1'b0;
                  rx_parity_bit = 1'b0;
               end
            end
         endcase
      end
   endtask

   function automatic int unsigned line_period();
      return (cfg_bit_period == 0) ? 1 : int'(cfg_bit_period);
   endfunction

   function automatic logic matching_parity(input logic [asrp_pkg::BYTE_BITS-1:0] value);
      return ^value ^ cfg_parity_odd;
   endfunction

   task automatic send_sample(input logic level);
      int gap;
      begin
         if (tx_idling && $urandom_range(0, 63) == 0) begin
            gap = $urandom_range(1, 19);
            req_bus.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_bus.valid = 1'b1;
         req_bus.line_level = level;
         do @(posedge clock); while (!req_bus.ready);
         decode_line_sample(level);
         samples_sent++;
         @(negedge clock);
      end
   endtask

   task automatic send_level(input logic level, input int unsigned count);
      repeat (count) send_sample(level);
   endtask

   task automatic send_frame(input logic [asrp_pkg::BYTE_BITS-1:0] value,
                             input logic parity_bit,
                             input int unsigned start_len, input int unsigned stop_len);
      int unsigned p;
      begin
         p = line_period();
         send_level(1'b0, start_len);
         for (int i = 0; i < asrp_pkg::BYTE_BITS; i++) send_level(value[i], p);
         send_level(parity_bit, p);
         send_level(1'b1, stop_len);
         frames_sent++;
      end
   endtask

   task automatic send_clean_frame(input logic [asrp_pkg::BYTE_BITS-1:0] value, input bit good);
      send_frame(value, matching_parity(value) ^ !good, line_period(), line_period());
   endtask

   task automatic wait_drained();
      req_bus.valid = 1'b0;
      while (pending_bytes.size() != 0) @(negedge clock);
   endtask

   // hold the line high until the receiver hunts, then drain before touching registers
   task automatic settle_idle();
      while (rx_phase != asrp_pkg::PHASE_HUNT) send_sample(1'b1);
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [asrp_pkg::CSR_INDEX_BITS-1:0] index,
                            input logic [asrp_pkg::PERIOD_BITS-1:0] value);
      csr_write_enable = 1'b1;
      csr_index = index;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      if (index == asrp_pkg::CSR_BIT_PERIOD) cfg_bit_period = value;
      else if (index == asrp_pkg::CSR_PARITY_ODD) cfg_parity_odd = value[0];
   endtask

   task automatic test_reset_defaults();
      write_csr(asrp_pkg::CSR_BIT_PERIOD, 16'd2);
      send_clean_frame(8'hA5, 1'b1);
      send_clean_frame(8'h3C, 1'b0);
   endtask

   task automatic test_parity_sense();
      settle_idle();
      write_csr(asrp_pkg::CSR_BIT_PERIOD, 16'd1);
      write_csr(asrp_pkg::CSR_PARITY_ODD, 16'hFFFE);
      send_clean_frame(8'h00, 1'b1);
      send_clean_frame(8'hFF, 1'b1);
      send_clean_frame(8'h00, 1'b0);
      send_clean_frame(8'hFF, 1'b0);
      send_clean_frame(8'h55, 1'b1);
      settle_idle();
      write_csr(asrp_pkg::CSR_PARITY_ODD, 16'h0001);
      send_clean_frame(8'h80, 1'b1);
      send_clean_frame(8'h01, 1'b0);
      settings_used += 2;
   endtask

   task automatic test_zero_period();
      settle_idle();
      write_csr(asrp_pkg::CSR_BIT_PERIOD, 16'd0);
      send_clean_frame(8'h00, 1'b1);
      send_clean_frame(8'hFF, 1'b0);
      send_clean_frame(8'hA5, 1'b1);
      settings_used++;
   endtask

   // start bit lands on the delivery tick and must only be seen on the next sample
   task automatic test_delivery_tick_restart();
      settle_idle();
      write_csr(asrp_pkg::CSR_BIT_PERIOD, 16'd1);
      send_frame(8'hC3, matching_parity(8'hC3), 1, 0);
      send_frame(8'h5A, matching_parity(8'h5A), 2, 1);
      settle_idle();
      write_csr(asrp_pkg::CSR_BIT_PERIOD, 16'd2);
      send_frame(8'h0F, matching_parity(8'h0F), 2, 1);
      send_frame(8'hF0, ~matching_parity(8'hF0), 3, 2);
      settings_used += 2;
   endtask

   task automatic test_unused_index();
      settle_idle();
      write_csr(asrp_pkg::CSR_BIT_PERIOD, 16'd3);
      for (int i = asrp_pkg::CSR_PARITY_ODD + 1; i < CSR_SLOTS; i++) begin
         write_csr(i[asrp_pkg::CSR_INDEX_BITS-1:0], 16'h0000);
         write_csr(i[asrp_pkg::CSR_INDEX_BITS-1:0], 16'hFFFF);
         write_csr(i[asrp_pkg::CSR_INDEX_BITS-1:0], 16'($urandom_range(0, 65535)));
      end
      send_clean_frame(8'h96, 1'b1);
      send_clean_frame(8'h69, 1'b0);
      settings_used++;
   endtask

   task automatic test_random_traffic();
      int unsigned p;
      int unsigned pick;
      logic [asrp_pkg::PERIOD_BITS-1:0] word;
      logic [asrp_pkg::BYTE_BITS-1:0] value;
      begin
         for (int s = 0; s < RANDOM_SETTINGS; s++) begin
            settle_idle();
            if (s >= RANDOM_SETTINGS - 2) begin
               tx_idling = 1'b0;
               rx_idling = 1'b0;
            end
            if (s == 0) word = '0;
            else word = 16'($urandom_range(1, 3));
            write_csr(asrp_pkg::CSR_BIT_PERIOD, word);
            word = 16'($urandom_range(0, 65535));
            write_csr(asrp_pkg::CSR_PARITY_ODD, word);
            if ($urandom_range(0, 2) == 0)
               write_csr(asrp_pkg::CSR_INDEX_BITS'($urandom_range(asrp_pkg::CSR_PARITY_ODD + 1,
                                                                  CSR_SLOTS - 1)),
                         16'($urandom_range(0, 65535)));
            settings_used++;
            p = line_period();
            for (int f = 0; f < FRAMES_PER_SETTING; f++) begin
               value = 8'($urandom_range(0, 255));
               pick = $urandom_range(0, 15);
               if (pick < 2) begin
                  // drop random levels on the line
                  repeat ($urandom_range(1, 12 * p + 12)) send_sample(1'($urandom_range(0, 1)));
               end else if (pick < 4) begin
                  // glitch: short low pulse on the idle line
                  send_level(1'b0, $urandom_range(1, p));
                  send_level(1'b1, $urandom_range(1, 12 * p));
               end else if (pick < 6) begin
                  send_frame(value, 1'($urandom_range(0, 1)), $urandom_range(1, p + 1),
                             $urandom_range(0, p));
               end else begin
                  send_frame(value, matching_parity(value) ^ ($urandom_range(0, 3) == 0),
                             p, p + $urandom_range(0, 2 * p));
               end
            end
         end
      end
   endtask

   // result checker and receive-side stall generator
   initial begin
      int stall_left;
      rx_byte_type want;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_bytes.size() == 0) begin
               $display("%0t: unexpected transaction data_byte %h parity_ok %b", $time,
                        rsp_bus.data_byte, rsp_bus.parity_ok);
               errors++;
            end else begin
               want = pending_bytes.pop_front();
               bytes_checked++;
               if (rsp_bus.data_byte !== want.data_byte) begin
                  $display("%0t: data_byte expected %h actual %h", $time, want.data_byte,
                           rsp_bus.data_byte);
                  errors++;
               end
               if (rsp_bus.parity_ok !== want.parity_ok) begin
                  $display("%0t: parity_ok expected %b actual %b", $time, want.parity_ok,
                           rsp_bus.parity_ok);
                  errors++;
               end
            end
         end
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready = 1'b0;
         end else if (rx_idling && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            rsp_bus.ready = 1'b0;
         end else begin
            rsp_bus.ready = !reset;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.line_level = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      repeat (7) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_parity_sense();
      test_zero_period();
      test_delivery_tick_restart();
      test_unused_index();
      test_random_traffic();

      while (rx_phase != asrp_pkg::PHASE_HUNT) send_sample(1'b1);
      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("sent %0d line samples carrying %0d frames over %0d register settings",
               samples_sent, frames_sent, settings_used);
      $display("checked %0d received bytes, %0d mismatches", bytes_checked, errors);
      if (errors == 0 && pending_bytes.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### filelist.f
src/asrp_pkg.sv
src/asrp_req_if.sv
src/asrp_rsp_if.sv
src/asrp_core.sv
src/asrp_out_reg.sv
src/async_serial_receiver_parity_unit.sv
src/asrp_checker.sv
dv/async_serial_receiver_parity_unit_test.sv
